@@ hw/rtl/lz_pkg.sv @@
`default_nettype none
package lz_pkg;

  localparam logic [7:0] END_FILL = 8'h5F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [6:0] match_distance;
    logic [6:0] match_length;
    logic [7:0] next_char;
    logic       end_token;
    logic       last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SEARCH,
    S_CONSUME,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic start;
    logic step;
    logic consume;
    logic emit;
    logic flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic la_will_fill;
    logic d_one;
    logic rem_zero;
    logic out_free;
    logic la_le_one;
  } stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/lz_ctrl.sv @@
`default_nettype none
module lz_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_final_i,
  output logic               in_ready_o,
  input  wire lz_pkg::stat_t stat_i,
  output lz_pkg::cmd_t       cmd_o
);
  import lz_pkg::*;

  state_e state_q, state_d;
  logic   flush_q, flush_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    flush_d    = flush_q;
    cmd_o      = '0;
    cmd_o.flush = flush_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          flush_d       = in_final_i;
          if (in_final_i || stat_i.la_will_fill) state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.start = 1'b1;
        state_d     = S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (stat_i.d_one) state_d = S_CONSUME;
      end
      S_CONSUME: begin
        if (stat_i.rem_zero) state_d = S_EMIT;
        else cmd_o.consume = 1'b1;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!flush_q) begin
            state_d = S_IDLE;
          end else if (stat_i.la_le_one) begin
            // stream done: drop history and lookahead
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/lz_dpath.sv @@
`default_nettype none
module lz_dpath #(
  parameter int W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire lz_pkg::in_t  in_data_i,
  input  wire lz_pkg::cmd_t cmd_i,
  output lz_pkg::stat_t     stat_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output lz_pkg::out_t      out_data_o
);
  import lz_pkg::*;

  localparam int DW  = $clog2(W + 1);
  localparam int LW  = $clog2(W + 2);
  localparam int LIW = $clog2(W + 1);

  logic [7:0]    hist_q [W];
  logic [7:0]    la_q   [W+1];
  logic [7:0]    cand_q [W];
  logic [DW-1:0] hc_q;
  logic [LW-1:0] la_cnt_q;
  logic [DW-1:0] d_q;
  logic [DW-1:0] best_len_q, best_dist_q, rem_q;
  logic          out_valid_q;
  out_t          out_q;

  logic [DW-1:0] len;
  logic [W-1:0]  hit;
  logic          better;
  logic          consume_en;

  // match length at the current candidate distance: first position that misses
  always_comb begin
    for (int j = 0; j < W; j++) begin
      hit[j] = (DW'(j) < d_q) && (LW'(j) < la_cnt_q) && (d_q <= hc_q) &&
               (cand_q[j] == la_q[j]);
    end
    len = DW'(W);
    for (int j = W - 1; j >= 0; j--) begin
      if (!hit[j]) len = DW'(j);
    end
  end

  assign better     = len > best_len_q;
  assign consume_en = cmd_i.consume || (cmd_i.emit && (la_cnt_q != '0));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in && (la_cnt_q < LW'(W + 1))) la_q[la_cnt_q[LIW-1:0]] <= in_data_i.data_byte;
    if (cmd_i.start) begin
      for (int j = 0; j < W; j++) cand_q[j] <= hist_q[W-1-j];
    end else if (cmd_i.step) begin
      for (int j = 0; j < W - 1; j++) cand_q[j] <= cand_q[j+1];
    end
    if (consume_en) begin
      for (int k = W - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
      hist_q[0] <= la_q[0];
      for (int k = 0; k < W; k++) la_q[k] <= la_q[k+1];
    end
    if (cmd_i.start) begin
      best_len_q  <= '0;
      best_dist_q <= '0;
    end else if (cmd_i.step && better) begin
      best_len_q  <= len;
      best_dist_q <= d_q;
    end
    if (cmd_i.step) rem_q <= better ? len : best_len_q;
    else if (cmd_i.consume) rem_q <= rem_q - DW'(1);
    if (cmd_i.start) d_q <= DW'(W);
    else if (cmd_i.step) d_q <= d_q - DW'(1);
    if (cmd_i.emit) begin
      out_q.match_distance <= 7'(best_dist_q);
      out_q.match_length   <= 7'(best_len_q);
      out_q.next_char      <= (la_cnt_q == '0) ? END_FILL : la_q[0];
      out_q.end_token      <= (la_cnt_q == '0);
      out_q.last_of_run    <= !cmd_i.flush || (la_cnt_q <= LW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q        <= '0;
      la_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        hc_q     <= '0;
        la_cnt_q <= '0;
      end else if (consume_en) begin
        if (hc_q != DW'(W)) hc_q <= hc_q + DW'(1);
        la_cnt_q <= la_cnt_q - LW'(1);
      end else if (cmd_i.load_in && (la_cnt_q < LW'(W + 1))) begin
        la_cnt_q <= la_cnt_q + LW'(1);
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.la_will_fill = (la_cnt_q == LW'(W));
  assign stat_o.d_one        = (d_q == DW'(1));
  assign stat_o.rem_zero     = (rem_q == '0);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;
  assign stat_o.la_le_one    = (la_cnt_q <= LW'(1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/lz77_token_encoder_top.sv @@
`default_nettype none
// LZ77 token encoder. Bytes that do not complete a token are taken one per cycle.
// A token is produced once the lookahead holds WINDOW+1 bytes, or for every token of
// the flush after a final byte; it runs a load step, a search over the WINDOW
// candidate distances (one per cycle through a shifting copy of the history, all
// lengths compared at once), a consume phase that moves each matched byte into the
// history at one per cycle, a step to leave that phase, and an emit step. Emit waits
// while the previous result is still held in the output register, so no new token
// search runs and no byte is taken while it waits.
module lz77_token_encoder_top #(
  parameter int WINDOW = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire lz_pkg::in_t in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output lz_pkg::out_t     out_data_o
);
  import lz_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_data_i.final_byte),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lz_dpath #(.W(WINDOW)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_end_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_token |-> out_data_o.next_char == END_FILL)
    else $error("end token without fill byte");

  a_len_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_length <= out_data_o.match_distance)
    else $error("match longer than its distance");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before taken");

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step || cmd.consume) |-> !in_ready_o)
    else $error("input taken during token work");

endmodule
`default_nettype wire
